### hw/rtl/lpht_pkg.sv
package lpht_pkg;

	localparam int TABLE_DEPTH_DEF = 128;
	localparam int KEY_W           = 63;
	localparam int DATA_W          = 64;
	localparam int FUNC_W          = 2;
	localparam int STATUS_W        = 2;
	// home slot reduction: one byte of the key per step
	localparam int MOD_DIGIT_W     = 8;
	localparam int MOD_STEPS       = 8;

	localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} entry_t;

	typedef struct packed {
		logic                clr_wr;
		logic                capture;
		logic                mod_step;
		logic                probe_init;
		logic                rd;
		logic                adv;
		logic                wr_ins;
		logic                wr_del;
		logic                res_load;
		logic [STATUS_W-1:0] res_status;
		logic                res_val;
		logic                out_load;
	} cmd_t;

	typedef struct packed {
		logic              clr_last;
		logic              mod_done;
		logic              slot_empty;
		logic              key_match;
		logic              probe_last;
		logic [FUNC_W-1:0] func;
	} sts_t;

endpackage

### hw/rtl/lpht_if.sv
interface lpht_in_if;
	import lpht_pkg::*;
	logic              valid;
	logic              ready;
	logic [FUNC_W-1:0] func;
	logic [KEY_W-1:0]  lookup_key;
	logic [DATA_W-1:0] entry_data;
	modport source (output valid, func, lookup_key, entry_data, input ready);
	modport sink (input valid, func, lookup_key, entry_data, output ready);
endinterface

interface lpht_out_if;
	import lpht_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   value_out;
	modport source (output valid, status, value_out, input ready);
	modport sink (input valid, status, value_out, output ready);
endinterface

### hw/rtl/lpht_dp.sv
module lpht_dp #(
	parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lpht_pkg::cmd_t                  cmd,
	output lpht_pkg::sts_t                  sts,
	input  logic [lpht_pkg::FUNC_W-1:0]     func,
	input  logic [lpht_pkg::KEY_W-1:0]      lookup_key,
	input  logic [lpht_pkg::DATA_W-1:0]     entry_data,
	output logic [lpht_pkg::STATUS_W-1:0]   status,
	output logic [lpht_pkg::DATA_W-1:0]     value_out
);
	import lpht_pkg::*;

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int RW = IW + 1;
	localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam int SW = $clog2(MOD_STEPS);
	localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_DEPTH - 1);
	localparam logic [RW-1:0] DEPTH_R = RW'(TABLE_DEPTH);

	entry_t mem [TABLE_DEPTH];

	logic [FUNC_W-1:0]       func_q;
	logic [KEY_W-1:0]        key_q;
	logic [DATA_W-1:0]       data_q;
	logic [IW-1:0]           rem_q;
	logic [SW-1:0]           mstep_q;
	logic [IW-1:0]           idx_q;
	logic [IW-1:0]           n_q;
	logic [IW-1:0]           clr_idx_q;
	entry_t                  rd_q;
	logic [STATUS_W-1:0]     res_status_q;
	logic [DATA_W-1:0]       res_value_q;
	logic [STATUS_W-1:0]     status_q;
	logic [DATA_W-1:0]       value_q;

	logic [IW-1:0]           idx_inc;
	logic [IW-1:0]           rd_addr;
	logic [IW-1:0]           home;
	logic [IW-1:0]           rem_nxt;
	logic [MOD_DIGIT_W-1:0]  digit;
	logic [KEY_W:0]          key_pad;

	assign key_pad = {1'b0, key_q};
	assign digit   = key_pad[(MOD_STEPS - 1 - int'(mstep_q)) * MOD_DIGIT_W +: MOD_DIGIT_W];

	// remainder update, one key byte per step, bits MSB first
	always_comb begin
		logic [RW-1:0] t;
		t = {1'b0, rem_q};
		for (int j = MOD_DIGIT_W - 1; j >= 0; j--) begin
			t = {t[IW-1:0], digit[j]};
			if (t >= DEPTH_R) begin
				t = t - DEPTH_R;
			end
		end
		rem_nxt = t[IW-1:0];
	end

	assign home    = IS_POW2 ? key_q[IW-1:0] : rem_q;
	assign idx_inc = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;
	assign rd_addr = cmd.adv ? idx_inc : idx_q;

	assign sts.clr_last   = clr_idx_q == LAST_SLOT;
	assign sts.mod_done   = IS_POW2 || (mstep_q == SW'(MOD_STEPS - 1));
	assign sts.slot_empty = rd_q.value == '0;
	assign sts.key_match  = rd_q.key == key_q;
	assign sts.probe_last = n_q == LAST_SLOT;
	assign sts.func       = func_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			mstep_q   <= '0;
			idx_q     <= '0;
			n_q       <= '0;
		end else begin
			if (cmd.clr_wr && !sts.clr_last) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cmd.capture) begin
				mstep_q <= '0;
			end else if (cmd.mod_step) begin
				mstep_q <= mstep_q + 1'b1;
			end
			if (cmd.probe_init) begin
				idx_q <= home;
				n_q   <= '0;
			end else if (cmd.adv) begin
				idx_q <= idx_inc;
				n_q   <= n_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			key_q  <= lookup_key;
			data_q <= entry_data;
			rem_q  <= '0;
		end else if (cmd.mod_step) begin
			rem_q <= rem_nxt;
		end
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_value_q  <= cmd.res_val ? rd_q.value : '0;
		end
		if (cmd.out_load) begin
			status_q <= res_status_q;
			value_q  <= res_value_q;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.clr_wr) begin
			mem[clr_idx_q] <= '0;
		end else if (cmd.wr_ins) begin
			mem[idx_q] <= '{key: key_q, value: data_q};
		end else if (cmd.wr_del) begin
			mem[idx_q] <= '{key: key_q, value: '0};
		end
		if (cmd.rd) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign status    = status_q;
	assign value_out = value_q;

endmodule

### hw/rtl/lpht_ctrl.sv
module lpht_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output lpht_pkg::cmd_t cmd,
	input  lpht_pkg::sts_t sts
);
	import lpht_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_START,
		S_RD,
		S_EV,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   is_ins;
	logic   is_match_op;

	assign is_ins      = sts.func == FN_INSERT;
	assign is_match_op = (sts.func == FN_SEARCH) || (sts.func == FN_DELETE);
	assign in_ready    = state_q == S_IDLE;
	assign out_valid   = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done) begin
					state_d = S_START;
				end
			end
			S_START: begin
				cmd.probe_init = 1'b1;
				if (is_ins || is_match_op) begin
					state_d = S_RD;
				end else begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_NOT_FOUND;
					state_d        = S_DONE;
				end
			end
			S_RD: begin
				cmd.rd  = 1'b1;
				state_d = S_EV;
			end
			S_EV: begin
				priority if (sts.slot_empty) begin
					cmd.res_load   = 1'b1;
					cmd.wr_ins     = is_ins;
					cmd.res_status = is_ins ? ST_OK : ST_NOT_FOUND;
					state_d        = S_DONE;
				end else if (sts.key_match && is_match_op) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = ST_OK;
					cmd.res_val    = 1'b1;
					cmd.wr_del     = sts.func == FN_DELETE;
					state_d        = S_DONE;
				end else if (sts.probe_last) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = is_ins ? ST_FULL : ST_NOT_FOUND;
					state_d        = S_DONE;
				end else begin
					cmd.adv = 1'b1;
					cmd.rd  = 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_ev_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EV |-> $past(cmd.rd))
		else $error("slot evaluated without a read");

	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("pending result beat overwritten");

	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_ins || cmd.wr_del) |-> (state_q == S_EV && !cmd.clr_wr && !cmd.adv))
		else $error("table write outside evaluation");

	a_clear_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR && sts.clr_last) |=> state_q == S_IDLE)
		else $error("clearing pass did not finish");

endmodule

### hw/rtl/linear_probe_hash_table.sv
// Open-addressing hash table, linear probing, TABLE_DEPTH slots of 63-bit key
// and 64-bit data. After reset a clearing pass runs over every slot while
// req.ready stays low. Each request beat is then captured and goes through the
// home-slot reduction (the key's low bits when TABLE_DEPTH is a power of two,
// otherwise MOD_STEPS steps of one key byte each); the walk starts in S_START
// and S_RD, probes up to TABLE_DEPTH slots, one slot per cycle, through the
// single registered read port of the slot memory, and the result is handed
// over to rsp. A new request is taken while the previous result beat still
// waits on rsp.
module linear_probe_hash_table #(
	parameter int TABLE_DEPTH = lpht_pkg::TABLE_DEPTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lpht_in_if.sink   req,
	lpht_out_if.source rsp
);
	import lpht_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lpht_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	lpht_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (req.func),
		.lookup_key (req.lookup_key),
		.entry_data (req.entry_data),
		.status     (rsp.status),
		.value_out  (rsp.value_out)
	);

endmodule

### tb/sv/linear_probe_hash_table_tb.sv
module linear_probe_hash_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpht_pkg::*;

	localparam int DEPTH      = TABLE_DEPTH_DEF;
	localparam int POOL_N     = 40;
	localparam int IDLE_LIMIT = 8 * DEPTH + 200;
	localparam int DRAIN      = 2 * DEPTH + 16;

	localparam logic [FUNC_W-1:0] FN_UNUSED  = 2'd3;
	localparam logic [DATA_W-1:0] EMPTY_MARK = '1;
	localparam logic [KEY_W-1:0]  KEY_MAX    = '1;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] data;
	} req_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [DATA_W-1:0]   value;
	} rsp_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	lpht_in_if  req_if ();
	lpht_out_if rsp_if ();

	linear_probe_hash_table #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow copy of the slot store
	logic [DATA_W-1:0] slot_key [DEPTH];
	logic [DATA_W-1:0] slot_val [DEPTH];

	req_beat_t  op_q [$];
	rsp_beat_t  expected_rsp [$];
	logic [KEY_W-1:0] key_pool [POOL_N];

	int   mismatches  = 0;
	int   idle_cycles = 0;
	int   burst_left  = 0;
	int   gap_left    = 0;
	int   win_left    = 0;
	logic [15:0] ready_pat = '1;
	logic taken = 1'b0;

	function automatic int probe_slot(input logic [KEY_W-1:0] key, input bit match,
			output bit found);
		int idx;
		found = 1'b0;
		idx = int'(key % DEPTH);
		for (int n = 0; n < DEPTH; n++) begin
			if (slot_key[idx] == EMPTY_MARK || slot_val[idx] == '0)
				return idx;
			if (match && slot_key[idx] == {1'b0, key}) begin
				found = 1'b1;
				return idx;
			end
			idx = (idx + 1) % DEPTH;
		end
		return DEPTH;
	endfunction

	task automatic table_apply(input req_beat_t b, output rsp_beat_t r);
		int idx;
		bit found;
		r.status = ST_NOT_FOUND;
		r.value  = '0;
		case (b.func)
			FN_SEARCH: begin
				idx = probe_slot(b.key, 1'b1, found);
				if (found) begin
					r.status = ST_OK;
					r.value  = slot_val[idx];
				end
			end
			FN_INSERT: begin
				idx = probe_slot(b.key, 1'b0, found);
				if (idx < DEPTH) begin
					slot_key[idx] = {1'b0, b.key};
					slot_val[idx] = b.data;
					r.status = ST_OK;
				end else begin
					r.status = ST_FULL;
				end
			end
			FN_DELETE: begin
				idx = probe_slot(b.key, 1'b1, found);
				if (found) begin
					r.status = ST_OK;
					r.value  = slot_val[idx];
					slot_key[idx] = EMPTY_MARK;
					slot_val[idx] = '0;
				end
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		mismatches++;
		$display("%0t: %s: got %h, expected %h", $realtime, what, got, want);
	endtask

	function automatic logic [DATA_W-1:0] rand_data();
		case ($urandom_range(0, 19))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		logic [DATA_W-1:0] r;
		r = {$urandom, $urandom};
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, POOL_N - 1)];
		return r[KEY_W-1:0];
	endfunction

	task automatic push_op(input logic [FUNC_W-1:0] fn, input logic [KEY_W-1:0] key,
			input logic [DATA_W-1:0] data);
		req_beat_t b;
		b.func = fn;
		b.key  = key;
		b.data = data;
		op_q.push_back(b);
	endtask

	task automatic gen_round(input int n, input int w_ins, input int w_del);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 5)
				push_op(FN_UNUSED, pick_key(), rand_data());
			else if (r < 5 + w_ins)
				push_op(FN_INSERT, pick_key(), rand_data());
			else if (r < 5 + w_ins + w_del)
				push_op(FN_DELETE, pick_key(), rand_data());
			else
				push_op(FN_SEARCH, pick_key(), rand_data());
		end
	endtask

	// request side: predict on every accepted beat
	always @(posedge clk) begin : accept_proc
		rsp_beat_t exp_beat;
		taken <= req_if.valid && req_if.ready;
		if (arst_n && req_if.valid && req_if.ready) begin
			table_apply('{func: req_if.func, key: req_if.lookup_key,
				data: req_if.entry_data}, exp_beat);
			expected_rsp.push_back(exp_beat);
		end
	end

	always @(negedge clk) begin : drive_proc
		req_beat_t cur;
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else if (req_if.valid && !taken) begin
		end else if (gap_left != 0) begin
			req_if.valid <= 1'b0;
			gap_left <= gap_left - 1;
		end else if (op_q.size() != 0) begin
			cur = op_q.pop_front();
			req_if.func       <= cur.func;
			req_if.lookup_key <= cur.key;
			req_if.entry_data <= cur.data;
			req_if.valid      <= 1'b1;
			if (burst_left <= 1) begin
				burst_left <= $urandom_range(1, 24);
				gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			end else begin
				burst_left <= burst_left - 1;
			end
		end else begin
			req_if.valid <= 1'b0;
		end
	end

	always @(negedge clk) begin : sink_proc
		logic [15:0] pat;
		pat = ready_pat;
		if (win_left == 0) begin
			case ($urandom_range(0, 3))
				0: pat = '1;
				1: pat = 16'h0001;
				default: pat = 16'($urandom) | 16'h0001;
			endcase
			win_left <= $urandom_range(20, 80);
		end else begin
			win_left <= win_left - 1;
		end
		rsp_if.ready <= arst_n && pat[0];
		ready_pat <= {pat[0], pat[15:1]};
	end

	always @(posedge clk) begin : check_proc
		rsp_beat_t exp_beat;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", rsp_if.value_out, '0);
			end else begin
				exp_beat = expected_rsp.pop_front();
				if (rsp_if.status !== exp_beat.status)
					report_mismatch("status", DATA_W'(rsp_if.status), DATA_W'(exp_beat.status));
				if (rsp_if.value_out !== exp_beat.value)
					report_mismatch("value_out", rsp_if.value_out, exp_beat.value);
			end
		end
	end

	always @(posedge clk) begin : watchdog_proc
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stim_proc
		logic [DATA_W-1:0] r;
		int h;
		arst_n = 1'b0;
		req_if.valid      = 1'b0;
		req_if.func       = FN_SEARCH;
		req_if.lookup_key = '0;
		req_if.entry_data = '0;
		rsp_if.ready      = 1'b0;
		for (int i = 0; i < DEPTH; i++) begin
			slot_key[i] = EMPTY_MARK;
			slot_val[i] = '0;
		end

		// keys clustered round both ends of the table to force collisions and wrap
		key_pool[0] = '0;
		key_pool[1] = KEY_MAX;
		for (int i = 2; i < POOL_N; i++) begin
			r = {$urandom, $urandom};
			h = $urandom_range(0, 9);
			h = (h < 5) ? h : DEPTH - 10 + h;
			r[KEY_W-1:0] = r[KEY_W-1:0] - (r[KEY_W-1:0] % DEPTH) + KEY_W'(h);
			key_pool[i] = r[KEY_W-1:0];
		end

		push_op(FN_SEARCH, '0, '0);
		push_op(FN_INSERT, '0, '1);
		push_op(FN_SEARCH, '0, '0);
		push_op(FN_INSERT, KEY_MAX, 64'd1);
		push_op(FN_INSERT, KEY_W'(DEPTH - 1), 64'h8000_0000_0000_0000);
		push_op(FN_SEARCH, KEY_W'(DEPTH - 1), '0);
		push_op(FN_SEARCH, KEY_MAX, '0);
		// zero data leaves the slot free
		push_op(FN_INSERT, 63'd5, '0);
		push_op(FN_SEARCH, 63'd5, '1);
		push_op(FN_INSERT, KEY_W'(DEPTH + 5), 64'h5555_5555_5555_5555);
		push_op(FN_SEARCH, KEY_W'(DEPTH + 5), '0);
		// duplicates, then delete without tombstone
		push_op(FN_INSERT, 63'd10, 64'h0123_4567_89ab_cdef);
		push_op(FN_INSERT, 63'd10, 64'hfedc_ba98_7654_3210);
		push_op(FN_SEARCH, 63'd10, '0);
		push_op(FN_DELETE, 63'd10, '0);
		push_op(FN_SEARCH, 63'd10, '0);
		push_op(FN_DELETE, 63'd10, '0);
		push_op(FN_UNUSED, '0, '1);
		push_op(FN_DELETE, KEY_MAX, '0);
		push_op(FN_SEARCH, KEY_W'(DEPTH - 1), '0);
		push_op(FN_DELETE, '0, '0);
		push_op(FN_INSERT, 63'h2aaa_aaaa_aaaa_aaaa, 64'haaaa_aaaa_aaaa_aaaa);

		gen_round(150, 50, 15);
		gen_round(150, 20, 40);
		gen_round(150, 50, 15);
		gen_round(150, 20, 40);

		// fill to capacity, then probe a full table
		for (int i = 0; i < DEPTH + 8; i++)
			push_op(FN_INSERT, pick_key(), rand_data() | 64'd1);
		for (int i = 0; i < 4; i++)
			push_op(FN_SEARCH, KEY_W'({$urandom, $urandom}), '0);
		for (int i = 0; i < 6; i++)
			push_op(FN_DELETE, key_pool[$urandom_range(0, POOL_N - 1)], '0);
		for (int i = 0; i < 8; i++)
			push_op(FN_INSERT, pick_key(), rand_data() | 64'd1);

		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		while (op_q.size() != 0 || req_if.valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### linear_probe_hash_table.f
hw/rtl/lpht_pkg.sv
hw/rtl/lpht_if.sv
hw/rtl/lpht_dp.sv
hw/rtl/lpht_ctrl.sv
hw/rtl/linear_probe_hash_table.sv
tb/sv/linear_probe_hash_table_tb.sv
